[design/mrts_pkg.sv]
// Shared types and constants for the mapped RAM with text screen block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mrts_pkg;

    localparam int SCREEN_COLUMNS = 40;
    localparam int SCREEN_LINES   = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_LINES;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int OFFSET_W  = 10;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 6;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam logic [ADDR_W-1:0] SCREEN_FIRST = 16'h0400;
    localparam logic [ADDR_W-1:0] SCREEN_LAST  = 16'h07E7;
    localparam logic [ADDR_W-1:0] COLOUR_FIRST = 16'hD800;
    localparam logic [ADDR_W-1:0] COLOUR_LAST  = 16'hDBE7;

    localparam logic [DATA_W-1:0] LOW_CODE_LIMIT = 8'd27;
    localparam logic [DATA_W-1:0] LOW_CODE_RAISE = 8'd64;

    localparam int ROW_RECIP_SHIFT = 13;
    localparam int ROW_RECIP       = ((1 << ROW_RECIP_SHIFT) + SCREEN_COLUMNS - 1)
                                     / SCREEN_COLUMNS;
    localparam int ROW_RECIP_W     = 8;
    localparam int ROW_PROD_W      = OFFSET_W + ROW_RECIP_W;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_SCREEN = 2'd2,
        KIND_COLOUR = 2'd3
    } kind_t;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              update_valid;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [DATA_W-1:0] char_code;
        logic [DATA_W-1:0] colour;
    } rsp_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   value;
        logic [DATA_W-1:0]   char_code;
        logic [OFFSET_W-1:0] offset;
        logic [ROW_W-1:0]    row;
    } cmd_t;

endpackage

[design/mrts_front.sv]
// Front end: accepts requests, classifies them by address window and
// precomputes cell offset, row and converted character. Uses mrts_pkg.
module mrts_front (
    input  logic          req_valid,
    output logic          req_stall,
    input  mrts_pkg::req_t req,
    input  logic          clearing,
    input  logic          q_full,
    output logic          q_push,
    output mrts_pkg::cmd_t q_data
);

    logic [mrts_pkg::ADDR_W-1:0]     scr_off;
    logic [mrts_pkg::ADDR_W-1:0]     col_off;
    logic                            in_scr;
    logic                            in_col;
    logic                            scr_hit;
    logic                            col_hit;
    logic [mrts_pkg::OFFSET_W-1:0]   offset;
    logic [mrts_pkg::ROW_PROD_W-1:0] row_prod;

    assign req_stall = q_full || clearing;
    assign q_push    = req_valid && !req_stall;

    assign scr_off = req.address - mrts_pkg::SCREEN_FIRST;
    assign col_off = req.address - mrts_pkg::COLOUR_FIRST;
    assign in_scr  = (req.address >= mrts_pkg::SCREEN_FIRST)
                  && (req.address <= mrts_pkg::SCREEN_LAST);
    assign in_col  = (req.address >= mrts_pkg::COLOUR_FIRST)
                  && (req.address <= mrts_pkg::COLOUR_LAST);
    assign scr_hit = in_scr && (scr_off < mrts_pkg::ADDR_W'(mrts_pkg::CELL_COUNT));
    assign col_hit = !in_scr && in_col
                  && (col_off < mrts_pkg::ADDR_W'(mrts_pkg::CELL_COUNT));

    assign offset   = in_scr ? scr_off[mrts_pkg::OFFSET_W-1:0]
                             : col_off[mrts_pkg::OFFSET_W-1:0];
    assign row_prod = mrts_pkg::ROW_PROD_W'(offset)
                    * mrts_pkg::ROW_PROD_W'(mrts_pkg::ROW_RECIP);

    always_comb
    begin
        q_data.address = req.address;
        q_data.value   = req.value;
        q_data.offset  = offset;
        q_data.row     = row_prod[mrts_pkg::ROW_RECIP_SHIFT +: mrts_pkg::ROW_W];
        if (req.value < mrts_pkg::LOW_CODE_LIMIT)
        begin
            q_data.char_code = req.value + mrts_pkg::LOW_CODE_RAISE;
        end
        else
        begin
            q_data.char_code = req.value;
        end
        priority if (req.action == mrts_pkg::ACT_READ)
        begin
            q_data.kind = mrts_pkg::KIND_READ;
        end
        else if (scr_hit)
        begin
            q_data.kind = mrts_pkg::KIND_SCREEN;
        end
        else if (col_hit)
        begin
            q_data.kind = mrts_pkg::KIND_COLOUR;
        end
        else
        begin
            q_data.kind = mrts_pkg::KIND_WRITE;
        end
    end

endmodule

[design/mrts_queue.sv]
// Short FIFO of classified requests between front and back ends.
// Uses mrts_pkg::cmd_t.
module mrts_queue #(
    parameter int DEPTH = mrts_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mrts_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output mrts_pkg::cmd_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrts_pkg::cmd_t   entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("pop from empty queue");

endmodule

[design/mrts_back.sv]
// Back end: clears and owns main, character and colour memories, carries out
// queued requests and holds the response register. Uses mrts_pkg.
module mrts_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  mrts_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           clearing,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mrts_pkg::rsp_t rsp
);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [mrts_pkg::ADDR_W-1:0]    clear_cnt_reg;
    logic [mrts_pkg::ADDR_W-1:0]    clear_cnt_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    mrts_pkg::kind_t                kind_reg;
    logic [mrts_pkg::ROW_W-1:0]     row_reg;
    logic [mrts_pkg::COL_W-1:0]     col_reg;
    logic [mrts_pkg::DATA_W-1:0]    char_new_reg;
    logic [mrts_pkg::DATA_W-1:0]    value_reg;
    logic [mrts_pkg::DATA_W-1:0]    main_rd_reg;
    logic [mrts_pkg::DATA_W-1:0]    char_rd_reg;
    logic [mrts_pkg::DATA_W-1:0]    colour_rd_reg;

    logic [mrts_pkg::DATA_W-1:0]    main_mem   [mrts_pkg::MEM_DEPTH];
    logic [mrts_pkg::DATA_W-1:0]    char_mem   [mrts_pkg::CELL_COUNT];
    logic [mrts_pkg::DATA_W-1:0]    colour_mem [mrts_pkg::CELL_COUNT];

    logic                           cell_clear;
    logic [mrts_pkg::OFFSET_W-1:0]  row_base;
    logic [mrts_pkg::OFFSET_W-1:0]  col_full;
    logic [mrts_pkg::OFFSET_W-1:0]  cell_addr;
    logic                           main_we;
    logic                           main_re;
    logic [mrts_pkg::ADDR_W-1:0]    main_waddr;
    logic [mrts_pkg::DATA_W-1:0]    main_wdata;
    logic                           char_we;
    logic                           char_re;
    logic [mrts_pkg::DATA_W-1:0]    char_wdata;
    logic                           colour_we;
    logic                           colour_re;
    logic [mrts_pkg::DATA_W-1:0]    colour_wdata;

    assign clearing   = (state_reg == ST_CLEAR);
    assign q_pop      = q_valid && !clearing && (!out_valid_reg || !rsp_stall);
    assign rsp_valid  = out_valid_reg;
    assign cell_clear = clearing
                     && (clear_cnt_reg < mrts_pkg::ADDR_W'(mrts_pkg::CELL_COUNT));

    assign row_base = mrts_pkg::OFFSET_W'(q_data.row)
                    * mrts_pkg::OFFSET_W'(mrts_pkg::SCREEN_COLUMNS);
    assign col_full = q_data.offset - row_base;

    assign cell_addr  = clearing ? clear_cnt_reg[mrts_pkg::OFFSET_W-1:0] : q_data.offset;
    assign main_waddr = clearing ? clear_cnt_reg : q_data.address;
    assign main_wdata = clearing ? '0 : q_data.value;
    assign main_we    = clearing || (q_pop && (q_data.kind != mrts_pkg::KIND_READ));
    assign main_re    = q_pop && (q_data.kind == mrts_pkg::KIND_READ);

    assign char_wdata = clearing ? '0 : q_data.char_code;
    assign char_we    = cell_clear || (q_pop && (q_data.kind == mrts_pkg::KIND_SCREEN));
    assign char_re    = q_pop && (q_data.kind == mrts_pkg::KIND_COLOUR);

    assign colour_wdata = clearing ? '0 : q_data.value;
    assign colour_we    = cell_clear || (q_pop && (q_data.kind == mrts_pkg::KIND_COLOUR));
    assign colour_re    = q_pop && (q_data.kind == mrts_pkg::KIND_SCREEN);

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + mrts_pkg::ADDR_W'(1);
                if (clear_cnt_reg == mrts_pkg::ADDR_W'(mrts_pkg::MEM_DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg     <= q_data.kind;
            row_reg      <= q_data.row;
            col_reg      <= col_full[mrts_pkg::COL_W-1:0];
            char_new_reg <= q_data.char_code;
            value_reg    <= q_data.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_we)
        begin
            main_mem[main_waddr] <= main_wdata;
        end
        if (main_re)
        begin
            main_rd_reg <= main_mem[q_data.address];
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            char_mem[cell_addr] <= char_wdata;
        end
        if (char_re)
        begin
            char_rd_reg <= char_mem[q_data.offset];
        end
    end

    always_ff @(posedge clk)
    begin
        if (colour_we)
        begin
            colour_mem[cell_addr] <= colour_wdata;
        end
        if (colour_re)
        begin
            colour_rd_reg <= colour_mem[q_data.offset];
        end
    end

    always_comb
    begin
        rsp = '0;
        unique case (kind_reg)
            mrts_pkg::KIND_READ:
            begin
                rsp.read_data = main_rd_reg;
            end
            mrts_pkg::KIND_WRITE:
            begin
                rsp = '0;
            end
            mrts_pkg::KIND_SCREEN:
            begin
                rsp.update_valid = 1'b1;
                rsp.row          = row_reg;
                rsp.column       = col_reg;
                rsp.char_code    = char_new_reg;
                rsp.colour       = colour_rd_reg;
            end
            mrts_pkg::KIND_COLOUR:
            begin
                rsp.update_valid = 1'b1;
                rsp.row          = row_reg;
                rsp.column       = col_reg;
                rsp.char_code    = char_rd_reg;
                rsp.colour       = value_reg;
            end
            default:
            begin
                rsp = '0;
            end
        endcase
    end

    a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("response during clearing pass");

    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CLEAR)
            && (clear_cnt_reg == mrts_pkg::ADDR_W'(mrts_pkg::MEM_DEPTH - 1)))
        |=> (state_reg == ST_RUN))
        else $error("clearing pass did not end");

    a_run_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |=> (state_reg == ST_RUN))
        else $error("returned to clearing pass");

    a_hold_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rsp_stall)
        |=> (out_valid_reg && $stable(kind_reg) && $stable(rsp)))
        else $error("stalled response changed");

endmodule

[design/mapped_ram_with_text_screen_top.sv]
// 64 KiB byte memory with a 40x25 text screen and colour map; top level.
// An accepted request is written into the queue, then carried out by the back end into the response register.
// Throughput: one request per cycle when no stall holds it, set by the single port of each memory.
// Reset: asynchronous; a clearing pass over every main memory address zeroes all memories,
// with req_stall high until it ends. Uses mrts_pkg, mrts_front/queue/back.
module mapped_ram_with_text_screen_top #(
    parameter int QUEUE_DEPTH = mrts_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  mrts_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mrts_pkg::rsp_t rsp
);

    logic           clearing;
    logic           q_full;
    logic           q_push;
    mrts_pkg::cmd_t q_push_data;
    logic           q_pop;
    logic           q_valid;
    mrts_pkg::cmd_t q_pop_data;

    mrts_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .clearing  (clearing),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    mrts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_data)
    );

    mrts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
